// ===== hdl/udpc_pkg.sv =====
package udpc_pkg;

    // Input word: one frame byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic [7:0] rx_queue;
    } in_word_t;

    // Result word: one verdict per frame
    typedef struct packed {
        logic       verdict;
        logic [7:0] queue_index;
    } out_word_t;

    // Parsed frame summary handed from parser to output stage
    typedef struct packed {
        logic        header_ok;
        logic [15:0] port;
        logic [7:0]  queue;
    } frame_sum_t;

    // Register indexes
    localparam logic REG_MATCH_PORT   = 1'b0;
    localparam logic REG_TARGET_QUEUE = 1'b1;

    localparam int CFG_DATA_W = 16;

    // Header constants
    localparam logic [6:0]  POS_MAX         = 7'd127;
    localparam logic [6:0]  POS_TYPE_HI     = 7'd12;
    localparam logic [6:0]  POS_TYPE_LO     = 7'd13;
    localparam logic [6:0]  POS_TAG_TYPE_HI = 7'd16;
    localparam logic [6:0]  POS_TAG_TYPE_LO = 7'd17;
    localparam logic [4:0]  IP_START_PLAIN  = 5'd14;
    localparam logic [4:0]  IP_START_TAGGED = 5'd18;
    localparam logic [15:0] ETH_TYPE_IP     = 16'h0800;
    localparam logic [15:0] ETH_TYPE_TAG_Q  = 16'h8100;
    localparam logic [15:0] ETH_TYPE_TAG_AD = 16'h88a8;
    localparam logic [7:0]  IP_PROTO_UDP    = 8'd17;
    localparam logic [3:0]  IP_VERSION      = 4'd4;
    localparam logic [3:0]  MIN_WORDS       = 4'd5;

    // Offsets inside the IPv4 header
    localparam logic [6:0] OFS_VER_IHL  = 7'd0;
    localparam logic [6:0] OFS_FRAG_HI  = 7'd6;
    localparam logic [6:0] OFS_FRAG_LO  = 7'd7;
    localparam logic [6:0] OFS_PROTO    = 7'd9;
    // Offsets inside the UDP header
    localparam logic [6:0] OFS_DPORT_HI = 7'd2;
    localparam logic [6:0] OFS_DPORT_LO = 7'd3;
    localparam logic [6:0] OFS_UDP_END  = 7'd7;

endpackage

// ===== hdl/udpc_parser.sv =====
module udpc_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_take,
    input  udpc_pkg::in_word_t   in_word,
    output logic                 sum_push,
    output udpc_pkg::frame_sum_t sum_word
);

    logic [6:0]  pos_reg,      pos_next;
    logic [15:0] kind_reg,     kind_next;
    logic [4:0]  ip_start_reg, ip_start_next;
    logic [3:0]  hwords_reg,   hwords_next;
    logic        ip_ok_reg,    ip_ok_next;
    logic [15:0] port_reg,     port_next;
    logic        udp_done_reg, udp_done_next;
    logic [7:0]  fq_reg,       fq_next;

    logic [7:0] b;
    logic [6:0] ip_start_ext;
    logic [6:0] rel;     // offset from IPv4 header start
    logic [6:0] udp_ofs; // IPv4 header length in bytes

    assign b            = in_word.data_byte;
    assign ip_start_ext = {2'b00, ip_start_reg};
    assign rel          = pos_reg - ip_start_ext;
    assign udp_ofs      = {1'b0, hwords_reg, 2'b00};

    always_comb begin
        kind_next     = kind_reg;
        ip_start_next = ip_start_reg;
        hwords_next   = hwords_reg;
        ip_ok_next    = ip_ok_reg;
        port_next     = port_reg;
        udp_done_next = udp_done_reg;
        fq_next       = (pos_reg == 7'd0) ? in_word.rx_queue : fq_reg;

        if (pos_reg == udpc_pkg::POS_TYPE_HI) begin
            kind_next = {b, kind_reg[7:0]};
        end else if (pos_reg == udpc_pkg::POS_TYPE_LO) begin
            kind_next = {kind_reg[15:8], b};
            if (kind_next == udpc_pkg::ETH_TYPE_IP) begin
                ip_start_next = udpc_pkg::IP_START_PLAIN;
                ip_ok_next    = 1'b1;
            end else if (kind_next == udpc_pkg::ETH_TYPE_TAG_Q ||
                         kind_next == udpc_pkg::ETH_TYPE_TAG_AD) begin
                ip_start_next = udpc_pkg::IP_START_TAGGED;
                ip_ok_next    = 1'b0;
            end else begin
                ip_start_next = 5'd0;
                ip_ok_next    = 1'b0;
            end
        end else if (ip_start_reg == udpc_pkg::IP_START_TAGGED &&
                     pos_reg == udpc_pkg::POS_TAG_TYPE_HI) begin
            kind_next = {b, kind_reg[7:0]};
        end else if (ip_start_reg == udpc_pkg::IP_START_TAGGED &&
                     pos_reg == udpc_pkg::POS_TAG_TYPE_LO) begin
            kind_next = {kind_reg[15:8], b};
            if (kind_next == udpc_pkg::ETH_TYPE_IP) begin
                ip_ok_next = 1'b1;
            end else begin
                ip_start_next = 5'd0;
                ip_ok_next    = 1'b0;
            end
        end else if (ip_ok_reg && pos_reg >= ip_start_ext) begin
            if (rel == udpc_pkg::OFS_VER_IHL) begin
                hwords_next = b[3:0];
                if (b[7:4] != udpc_pkg::IP_VERSION || b[3:0] < udpc_pkg::MIN_WORDS) begin
                    ip_ok_next = 1'b0;
                end
            end else if (rel == udpc_pkg::OFS_FRAG_HI) begin
                // reserved and DF bits masked off; MF and fragment offset high bits must be zero
                if (b[5:0] != 6'd0) begin
                    ip_ok_next = 1'b0;
                end
            end else if (rel == udpc_pkg::OFS_FRAG_LO) begin
                if (b != 8'd0) begin
                    ip_ok_next = 1'b0;
                end
            end else if (rel == udpc_pkg::OFS_PROTO) begin
                if (b != udpc_pkg::IP_PROTO_UDP) begin
                    ip_ok_next = 1'b0;
                end
            end else if (rel == udp_ofs + udpc_pkg::OFS_DPORT_HI) begin
                port_next = {b, port_reg[7:0]};
            end else if (rel == udp_ofs + udpc_pkg::OFS_DPORT_LO) begin
                port_next = {port_reg[15:8], b};
            end else if (rel == udp_ofs + udpc_pkg::OFS_UDP_END) begin
                udp_done_next = 1'b1;
            end
        end

        pos_next = (pos_reg < udpc_pkg::POS_MAX) ? pos_reg + 7'd1 : pos_reg;
    end

    assign sum_push           = byte_take && in_word.last_byte;
    assign sum_word.header_ok = ip_ok_next && udp_done_next;
    assign sum_word.port      = port_next;
    assign sum_word.queue     = fq_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_take && in_word.last_byte)) begin
            pos_reg      <= 7'd0;
            kind_reg     <= 16'd0;
            ip_start_reg <= 5'd0;
            hwords_reg   <= 4'd0;
            ip_ok_reg    <= 1'b0;
            port_reg     <= 16'd0;
            udp_done_reg <= 1'b0;
            fq_reg       <= 8'd0;
        end else if (byte_take) begin
            pos_reg      <= pos_next;
            kind_reg     <= kind_next;
            ip_start_reg <= ip_start_next;
            hwords_reg   <= hwords_next;
            ip_ok_reg    <= ip_ok_next;
            port_reg     <= port_next;
            udp_done_reg <= udp_done_next;
            fq_reg       <= fq_next;
        end
    end

endmodule

// ===== hdl/udpc_fifo.sv =====
module udpc_fifo #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/udpc_verdict.sv =====
module udpc_verdict #(
    parameter int QUEUE_WIDTH = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [udpc_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                sum_valid,
    input  udpc_pkg::frame_sum_t                sum_word,
    output logic                                sum_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output udpc_pkg::out_word_t                 m_data
);

    // Only the low bits of the 8-bit queue numbers take part in the match
    localparam int CMP_W = (QUEUE_WIDTH < 8) ? QUEUE_WIDTH : 8;

    logic [15:0]         match_port_reg;
    logic [7:0]          target_queue_reg;
    logic                m_valid_reg, m_valid_next;
    udpc_pkg::out_word_t m_data_reg,  m_data_next;
    logic                hit;

    assign hit = sum_word.header_ok &&
                 (sum_word.port == match_port_reg) &&
                 (sum_word.queue[CMP_W-1:0] == target_queue_reg[CMP_W-1:0]);

    assign sum_pop = sum_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (sum_pop) begin
            m_valid_next            = 1'b1;
            m_data_next.verdict     = hit;
            m_data_next.queue_index = sum_word.queue;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            match_port_reg   <= 16'd0;
            target_queue_reg <= 8'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    udpc_pkg::REG_MATCH_PORT: begin
                        match_port_reg <= cfg_wr_data;
                    end
                    udpc_pkg::REG_TARGET_QUEUE: begin
                        target_queue_reg <= cfg_wr_data[7:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/udp_port_packet_classifier_core.sv =====
// A verdict word passes from the parser through the summary queue into the output
// register; m_valid rises when that register is free to take it.
// Throughput: one frame byte per cycle; the parser takes a byte every cycle that the
// two-entry summary queue between parser and output register has room.
// Reset: aresetn is synchronous, active low; it clears the parser state, the queue,
// the output valid and both configuration registers (match port, target_queue) to 0.
module udp_port_packet_classifier_core #(
    parameter int QUEUE_WIDTH = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [udpc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // frame bytes in
    input  logic                            s_valid,
    output logic                            s_ready,
    input  udpc_pkg::in_word_t              s_data,
    // verdicts out
    output logic                            m_valid,
    input  logic                            m_ready,
    output udpc_pkg::out_word_t             m_data
);

    localparam int SUM_W     = $bits(udpc_pkg::frame_sum_t);
    localparam int SUM_DEPTH = 2;

    logic                 byte_take;
    logic                 sum_push;
    udpc_pkg::frame_sum_t sum_in;
    udpc_pkg::frame_sum_t sum_head;
    logic                 q_full;
    logic                 q_not_empty;
    logic                 q_pop;

    // Front end: byte parser. Stalls only when the summary queue is full,
    // which is checked for every byte so a last byte never finds it full.
    assign s_ready   = !q_full;
    assign byte_take = s_valid && s_ready;

    udpc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_take (byte_take),
        .in_word   (s_data),
        .sum_push  (sum_push),
        .sum_word  (sum_in)
    );

    // Short queue of per-frame summaries; decouples parsing from output stalls.
    udpc_fifo #(
        .WIDTH (SUM_W),
        .DEPTH (SUM_DEPTH)
    ) u_sum_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (sum_push),
        .push_data (sum_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (sum_head)
    );

    // Back end: match against configuration and hold the verdict word
    // in the output register until taken.
    udpc_verdict #(
        .QUEUE_WIDTH (QUEUE_WIDTH)
    ) u_verdict (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .sum_valid   (q_not_empty),
        .sum_word    (sum_head),
        .sum_pop     (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== sim/tb_udp_port_packet_classifier_core.sv =====
`timescale 1ns / 1ps

module tb_udp_port_packet_classifier_core;
    import udpc_pkg::*;

    localparam int QUEUE_WIDTH = 8;
    // only the low QUEUE_WIDTH bits of the queue numbers take part in the match
    localparam logic [7:0] QUEUE_MASK =
        (QUEUE_WIDTH >= 8) ? 8'hff : 8'((1 << QUEUE_WIDTH) - 1);
    localparam logic [15:0] FRAG_MASK = 16'h3fff;

    localparam int RANDOM_BYTES   = 1080;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;  // cycles without any handshake

    // Header predictor plus the queue of verdict words still owed by the block.
    class verdict_board;
        logic [15:0] match_port;
        logic [7:0]  target_queue;

        // per-frame parse state
        logic [6:0]  pos;
        logic [15:0] eth_type;
        logic [4:0]  l3_ofs;
        logic [3:0]  ihl;
        logic        l3_good;
        logic [15:0] dst_port;
        logic        udp_whole;
        logic [7:0]  frame_q;

        out_word_t verdicts_due[$];
        int        errors;

        function new();
            match_port   = '0;
            target_queue = '0;
            errors       = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            pos       = '0;
            eth_type  = '0;
            l3_ofs    = '0;
            ihl       = '0;
            l3_good   = 1'b0;
            dst_port  = '0;
            udp_whole = 1'b0;
            frame_q   = '0;
        endfunction

        function void write_reg(logic idx, logic [15:0] value);
            if (idx == REG_MATCH_PORT)
                match_port = value;
            else if (idx == REG_TARGET_QUEUE)
                target_queue = value[7:0];
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        // Called for every accepted input word.
        function void note_byte(in_word_t w);
            logic [7:0] b;
            int         r;
            int         u;
            out_word_t  v;
            b = w.data_byte;
            if (pos == 0)
                frame_q = w.rx_queue;

            if (pos == POS_TYPE_HI) begin
                eth_type[15:8] = b;
            end else if (pos == POS_TYPE_LO) begin
                eth_type[7:0] = b;
                if (eth_type == ETH_TYPE_IP) begin
                    l3_ofs  = IP_START_PLAIN;
                    l3_good = 1'b1;
                end else if (eth_type == ETH_TYPE_TAG_Q || eth_type == ETH_TYPE_TAG_AD) begin
                    l3_ofs  = IP_START_TAGGED;
                    l3_good = 1'b0;
                end else begin
                    l3_ofs  = '0;
                    l3_good = 1'b0;
                end
            end else if (l3_ofs == IP_START_TAGGED && pos == POS_TAG_TYPE_HI) begin
                eth_type[15:8] = b;
            end else if (l3_ofs == IP_START_TAGGED && pos == POS_TAG_TYPE_LO) begin
                eth_type[7:0] = b;
                if (eth_type == ETH_TYPE_IP) begin
                    l3_good = 1'b1;
                end else begin
                    l3_ofs  = '0;
                    l3_good = 1'b0;
                end
            end else if (l3_good && pos >= l3_ofs) begin
                r = int'(pos) - int'(l3_ofs);
                u = int'(ihl) * 4;
                if (r == int'(OFS_VER_IHL)) begin
                    ihl = b[3:0];
                    if (b[7:4] != IP_VERSION || b[3:0] < MIN_WORDS)
                        l3_good = 1'b0;
                end else if (r == int'(OFS_FRAG_HI)) begin
                    if (({b, 8'h00} & FRAG_MASK) != 0)
                        l3_good = 1'b0;
                end else if (r == int'(OFS_FRAG_LO)) begin
                    if (({8'h00, b} & FRAG_MASK) != 0)
                        l3_good = 1'b0;
                end else if (r == int'(OFS_PROTO)) begin
                    if (b != IP_PROTO_UDP)
                        l3_good = 1'b0;
                end else if (r == u + int'(OFS_DPORT_HI)) begin
                    dst_port[15:8] = b;
                end else if (r == u + int'(OFS_DPORT_LO)) begin
                    dst_port[7:0] = b;
                end else if (r == u + int'(OFS_UDP_END)) begin
                    udp_whole = 1'b1;
                end
            end

            if (pos < POS_MAX)
                pos++;

            if (w.last_byte) begin
                v.verdict = l3_good && udp_whole && dst_port == match_port &&
                            ((frame_q ^ target_queue) & QUEUE_MASK) == 8'h00;
                v.queue_index = frame_q;
                verdicts_due.push_back(v);
                restart_frame();
            end
        endfunction

        function void check_verdict(out_word_t got);
            out_word_t want;
            if (verdicts_due.size() == 0) begin
                $error("verdict word with none expected: verdict=%0d queue_index=%0d",
                       got.verdict, got.queue_index);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.verdict !== want.verdict) begin
                $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                errors++;
            end
            if (got.queue_index !== want.queue_index) begin
                $error("queue_index: expected %0d, got %0d",
                       want.queue_index, got.queue_index);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_index   = REG_MATCH_PORT;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_word_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_word_t   m_data;

    verdict_board sb = new();

    logic [7:0] frame_bytes[$];   // frame under construction
    int         bytes_sent = 0;
    int         burst_left = 0;
    bit         calm       = 1'b0; // no idling on either side while set

    udp_port_packet_classifier_core #(
        .QUEUE_WIDTH(QUEUE_WIDTH)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver: a random ready mask that rotates every cycle, reloaded when its
    // random countdown runs out; about a quarter of the masks never stall.
    logic [15:0] ready_bits = 16'hffff;
    int          ready_left = 0;
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_left = $urandom_range(16, 96);
            ready_bits = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
        end
        ready_left--;
        m_ready <= calm | ready_bits[0];
        ready_bits = {ready_bits[0], ready_bits[15:1]};
    end

    // Result monitor and watchdog. Values read here are the ones present
    // at the edge, since every driver uses nonblocking updates.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_verdict(m_data);
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[udp_port_packet_classifier_core] ERROR");
            $finish;
        end
    end

    // Header offset of the IPv4 header for a given tag (0 means untagged).
    function automatic int l3_start(logic [15:0] tag);
        return (tag == 16'h0000) ? int'(IP_START_PLAIN) : int'(IP_START_TAGGED);
    endfunction

    // Well-formed Ethernet / optional tag / IPv4 / UDP frame with random
    // content; extra is the UDP payload length.
    function automatic void build_udp_frame(logic [15:0] tag, logic [3:0] hdr_len,
                                            logic [15:0] dport, int extra);
        frame_bytes.delete();
        repeat (12) frame_bytes.push_back(8'($urandom));      // MAC addresses
        if (tag != 16'h0000) begin
            frame_bytes.push_back(tag[15:8]);
            frame_bytes.push_back(tag[7:0]);
            repeat (2) frame_bytes.push_back(8'($urandom));    // TCI
        end
        frame_bytes.push_back(ETH_TYPE_IP[15:8]);
        frame_bytes.push_back(ETH_TYPE_IP[7:0]);
        frame_bytes.push_back({IP_VERSION, hdr_len});
        repeat (5) frame_bytes.push_back(8'($urandom));        // tos, length, id
        frame_bytes.push_back({2'($urandom), 6'b000000});      // reserved / DF only
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'($urandom));                   // ttl
        frame_bytes.push_back(IP_PROTO_UDP);
        repeat (int'(hdr_len) * 4 - 10) frame_bytes.push_back(8'($urandom));
        repeat (2) frame_bytes.push_back(8'($urandom));        // source port
        frame_bytes.push_back(dport[15:8]);
        frame_bytes.push_back(dport[7:0]);
        repeat (4 + extra) frame_bytes.push_back(8'($urandom));
    endfunction

    // Spoil header fields of the frame just built, or cut it short.
    function automatic void break_frame(logic [15:0] tag);
        int o;
        int keep;
        o = l3_start(tag);
        case ($urandom_range(0, 7))
            0: frame_bytes[o - 2] = 8'($urandom);
            1: frame_bytes[o] = {4'($urandom), frame_bytes[o][3:0]};
            2: frame_bytes[o] = {IP_VERSION, 4'($urandom_range(0, 4))};
            3: frame_bytes[o + 6] = {frame_bytes[o + 6][7:6], 6'($urandom)};
            4: frame_bytes[o + 7] = 8'($urandom);
            5: frame_bytes[o + 9] = 8'($urandom);
            6: begin
                keep = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > keep)
                    void'(frame_bytes.pop_back());
            end
            default: begin
                // tag in front of a tag, or a tag type where IPv4 was
                frame_bytes[12] = ETH_TYPE_TAG_Q[15:8];
                frame_bytes[13] = ETH_TYPE_TAG_Q[7:0];
                frame_bytes[16] = ETH_TYPE_TAG_AD[15:8];
                frame_bytes[17] = ETH_TYPE_TAG_AD[7:0];
            end
        endcase
    endfunction

    // One word per call; bursts of random length with random gaps in between while calm is clear.
    task automatic push_byte(in_word_t w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(w);
        bytes_sent++;
    endtask

    // Send frame_bytes; with wobble set the queue number moves after byte 0.
    task automatic send_frame(logic [7:0] q, bit wobble);
        in_word_t w;
        foreach (frame_bytes[i]) begin
            w.data_byte = frame_bytes[i];
            w.last_byte = (i == frame_bytes.size() - 1);
            w.rx_queue  = (i == 0 || !wobble) ? q : 8'($urandom);
            push_byte(w);
        end
    endtask

    // Register writes only once the block has gone quiet.
    task automatic program_regs(logic [15:0] port, logic [15:0] queue_word);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_MATCH_PORT;
        cfg_wr_data <= port;
        @(posedge aclk);
        sb.write_reg(REG_MATCH_PORT, port);
        cfg_index   <= REG_TARGET_QUEUE;
        cfg_wr_data <= queue_word;
        @(posedge aclk);
        sb.write_reg(REG_TARGET_QUEUE, queue_word);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly good UDP frames aimed at the configured port and queue; the
    // rest are spoiled frames and plain noise.
    task automatic random_frame();
        int          pick;
        logic [15:0] tag;
        logic [3:0]  hdr_len;
        logic [15:0] dport;
        logic [7:0]  q;
        int          extra;
        pick  = $urandom_range(0, 99);
        q     = ($urandom_range(0, 3) != 0) ? sb.target_queue : 8'($urandom);
        if (pick < 10) begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 80)) frame_bytes.push_back(8'($urandom));
        end else begin
            case ($urandom_range(0, 2))
                0:       tag = 16'h0000;
                1:       tag = ETH_TYPE_TAG_Q;
                default: tag = ETH_TYPE_TAG_AD;
            endcase
            hdr_len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : MIN_WORDS;
            dport   = ($urandom_range(0, 4) != 0) ? sb.match_port : 16'($urandom);
            extra   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
            build_udp_frame(tag, hdr_len, dport, extra);
            if (pick >= 75)
                break_frame(tag);
        end
        send_frame(q, $urandom_range(0, 7) == 0);
    endtask

    initial begin
        int start;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values of the registers: port 0 on queue 0 redirects.
        build_udp_frame(16'h0000, MIN_WORDS, 16'h0000, 0);
        send_frame(8'h00, 1'b0);
        build_udp_frame(16'h0000, MIN_WORDS, 16'h0000, 5);
        send_frame(8'h01, 1'b0);

        // Directed cases, registers at their top values.
        program_regs(16'hffff, 16'hffff);
        // shortest complete frame, then the same one byte short
        build_udp_frame(16'h0000, MIN_WORDS, 16'hffff, 0);
        send_frame(8'hff, 1'b0);
        build_udp_frame(16'h0000, MIN_WORDS, 16'hffff, 0);
        void'(frame_bytes.pop_back());
        send_frame(8'hff, 1'b0);
        // longest header behind a tag, frame runs past position 127
        build_udp_frame(ETH_TYPE_TAG_Q, 4'd15, 16'hffff, 100);
        send_frame(8'hff, 1'b0);
        // DF and reserved flag bits are outside the fragment check
        build_udp_frame(ETH_TYPE_TAG_AD, MIN_WORDS, 16'hffff, 3);
        frame_bytes[l3_start(ETH_TYPE_TAG_AD) + 6] = 8'hc0;
        send_frame(8'hff, 1'b0);
        // a tag inside the tag
        build_udp_frame(ETH_TYPE_TAG_Q, MIN_WORDS, 16'hffff, 0);
        frame_bytes[16] = ETH_TYPE_TAG_AD[15:8];
        frame_bytes[17] = ETH_TYPE_TAG_AD[7:0];
        send_frame(8'hff, 1'b0);
        // queue changes after the first byte
        build_udp_frame(16'h0000, MIN_WORDS, 16'hffff, 2);
        send_frame(8'hff, 1'b1);
        // queue and port mismatches
        build_udp_frame(16'h0000, MIN_WORDS, 16'hffff, 0);
        send_frame(8'h7f, 1'b0);
        build_udp_frame(16'h0000, MIN_WORDS, 16'h7fff, 0);
        send_frame(8'hff, 1'b0);
        build_udp_frame(16'h0000, MIN_WORDS, 16'hfffe, 0);
        send_frame(8'hff, 1'b0);
        // MF flag, fragment offset
        build_udp_frame(16'h0000, MIN_WORDS, 16'hffff, 0);
        frame_bytes[l3_start(16'h0000) + 6] = 8'h20;
        send_frame(8'hff, 1'b0);
        build_udp_frame(16'h0000, MIN_WORDS, 16'hffff, 0);
        frame_bytes[l3_start(16'h0000) + 7] = 8'h01;
        send_frame(8'hff, 1'b0);
        // wrong version, short header, other protocol, other Ethernet type
        build_udp_frame(16'h0000, MIN_WORDS, 16'hffff, 0);
        frame_bytes[l3_start(16'h0000)] = 8'h65;
        send_frame(8'hff, 1'b0);
        build_udp_frame(16'h0000, MIN_WORDS, 16'hffff, 0);
        frame_bytes[l3_start(16'h0000)] = 8'h44;
        send_frame(8'hff, 1'b0);
        build_udp_frame(16'h0000, MIN_WORDS, 16'hffff, 0);
        frame_bytes[l3_start(16'h0000) + 9] = 8'h06;
        send_frame(8'hff, 1'b0);
        build_udp_frame(16'h0000, MIN_WORDS, 16'hffff, 0);
        frame_bytes[12] = 8'h86;
        frame_bytes[13] = 8'hdd;
        send_frame(8'hff, 1'b0);
        // single-byte frame
        frame_bytes.delete();
        frame_bytes.push_back(8'hff);
        send_frame(8'h00, 1'b0);

        // Random part in four settings; the third runs with no idling.
        start = bytes_sent;
        program_regs(16'h0000, 16'h0000);
        while (bytes_sent < start + RANDOM_BYTES / 4) random_frame();
        program_regs(16'($urandom), 16'($urandom));
        while (bytes_sent < start + RANDOM_BYTES / 2) random_frame();
        program_regs(16'($urandom), 16'($urandom));
        calm = 1'b1;
        while (bytes_sent < start + 3 * RANDOM_BYTES / 4) random_frame();
        program_regs(16'h8001, 16'hff80);
        calm = 1'b0;
        while (bytes_sent < start + RANDOM_BYTES) random_frame();

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("[udp_port_packet_classifier_core] OK");
        else
            $display("[udp_port_packet_classifier_core] ERROR");
        $finish;
    end

endmodule
